// ----- rtl/largest_prime_factor_assert.svh -----
// Assertion macros for the largest prime factor block.
`ifndef LARGEST_PRIME_FACTOR_ASSERT_SVH
`define LARGEST_PRIME_FACTOR_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define LPF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("largest_prime_factor: check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define LPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("largest_prime_factor: check failed");

`endif

// ----- rtl/lpf_pkg.sv -----
// Shared constants, types and command/status structs for the prime factor block.
package lpf_pkg;

    localparam int DATA_WIDTH = 32;                  // arithmetic width
    localparam int FIELD_W    = 32;                  // port field width
    localparam int D_W        = DATA_WIDTH / 2 + 2;  // trial divisor width
    localparam int SQ_W       = DATA_WIDTH + 2;      // divisor squared width
    localparam int CNT_W      = $clog2(DATA_WIDTH);  // divider bit counter

    localparam logic [D_W-1:0]  D_INIT  = D_W'(3);
    localparam logic [SQ_W-1:0] SQ_INIT = SQ_W'(9);
    localparam logic [SQ_W-1:0] SQ_STEP = SQ_W'(4);
    localparam logic [DATA_WIDTH-1:0] TWO = DATA_WIDTH'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STRIP,
        ST_CHECK,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;       // take a new number
        logic shift_two;  // divide out one factor of two
        logic div_start;  // start trial division r / d
        logic apply;      // r <= quotient, best <= d
        logic next_d;     // d += 2, square updated
        logic finish;     // best <= r when r > 2
        logic out_load;   // move result to output register
    } cmd_t;

    typedef struct packed {
        logic below_two;  // number below two
        logic r_even;
        logic sq_gt_r;    // d*d > r, search over
        logic div_done;
        logic rem_zero;
    } stat_t;

endpackage

// ----- rtl/lpf_div.sv -----
// Restoring divider, one quotient bit per cycle.
module lpf_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [lpf_pkg::DATA_WIDTH-1:0] dividend,
    input  logic [lpf_pkg::DATA_WIDTH-1:0] divisor,
    output logic                           done,
    output logic [lpf_pkg::DATA_WIDTH-1:0] quotient,
    output logic                           rem_zero
);
    import lpf_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] quot_reg, quot_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] dsor_reg, dsor_next;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;

    assign rem_sh = {rem_reg, quot_reg[DATA_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, dsor_reg};
    assign ge     = rem_sh >= {1'b0, dsor_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsor_next = dsor_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            dsor_next = divisor;
        end else if (busy_reg) begin
            quot_next = {quot_reg[DATA_WIDTH-2:0], ge};
            rem_next  = ge ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DATA_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsor_reg <= dsor_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

// ----- rtl/lpf_datapath.sv -----
// Datapath: remainder, trial divisor and its square, best factor, output register.
module lpf_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lpf_pkg::cmd_t               cmd,
    output lpf_pkg::stat_t              stat,
    input  logic [lpf_pkg::FIELD_W-1:0] number,
    output logic [lpf_pkg::FIELD_W-1:0] largest_factor,
    output logic                        has_factor
);
    import lpf_pkg::*;

    logic [DATA_WIDTH-1:0] r_reg, r_next;
    logic [DATA_WIDTH-1:0] best_reg, best_next;
    logic [D_W-1:0]        d_reg, d_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic                  below_two_reg, below_two_next;
    logic [FIELD_W-1:0]    out_factor_reg;
    logic                  out_has_reg;
    logic [DATA_WIDTH-1:0] num_w;
    logic [DATA_WIDTH-1:0] quotient;
    logic                  div_done;
    logic                  rem_zero;

    assign num_w = DATA_WIDTH'(number);

    lpf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (r_reg),
        .divisor  (DATA_WIDTH'(d_reg)),
        .done     (div_done),
        .quotient (quotient),
        .rem_zero (rem_zero)
    );

    always_comb begin
        r_next         = r_reg;
        best_next      = best_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        below_two_next = below_two_reg;
        if (cmd.load) begin
            r_next         = num_w;
            best_next      = '0;
            d_next         = D_INIT;
            sq_next        = SQ_INIT;
            below_two_next = (num_w < TWO);
        end
        if (cmd.shift_two) begin
            r_next    = r_reg >> 1;
            best_next = TWO;
        end
        if (cmd.apply) begin
            r_next    = quotient;
            best_next = DATA_WIDTH'(d_reg);
        end
        if (cmd.next_d) begin
            // (d+2)^2 = d^2 + 4d + 4
            d_next  = d_reg + D_W'(2);
            sq_next = sq_reg + SQ_W'({d_reg, 2'b00}) + SQ_STEP;
        end
        if (cmd.finish && (r_reg > TWO)) begin
            best_next = r_reg;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg         <= r_next;
        best_reg      <= best_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        below_two_reg <= below_two_next;
        if (cmd.out_load) begin
            out_factor_reg <= FIELD_W'(best_reg);
            out_has_reg    <= !below_two_reg;
        end
    end

    assign stat.below_two = below_two_reg;
    assign stat.r_even    = !r_reg[0];
    assign stat.sq_gt_r   = sq_reg > SQ_W'(r_reg);
    assign stat.div_done  = div_done;
    assign stat.rem_zero  = rem_zero;

    assign largest_factor = out_factor_reg;
    assign has_factor     = out_has_reg;

endmodule

// ----- rtl/lpf_ctrl.sv -----
// Controller: sequences stripping of twos, odd trial divisions and result hand-off.
module lpf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  lpf_pkg::stat_t stat,
    output lpf_pkg::cmd_t  cmd
);
    import lpf_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                priority if (stat.below_two) begin
                    state_next = ST_DONE;
                end else if (stat.r_even) begin
                    cmd.shift_two = 1'b1;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.sq_gt_r) begin
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (stat.div_done) begin
                    // same divisor again after a hit, next odd one after a miss
                    if (stat.rem_zero) begin
                        cmd.apply = 1'b1;
                    end else begin
                        cmd.next_d = 1'b1;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/largest_prime_factor.sv -----
// Top level of the largest prime factor block: controller, datapath and checks.
//
// Takes one unsigned 32-bit number per input word and returns one result word:
// its largest prime factor and a flag that is set when the number is at least 2
// (for 0 and 1 the flag is clear and the factor reads 0). Factors of two are
// shifted out one per cycle, then odd divisors d = 3, 5, 7, ... are tried while
// d*d does not exceed the shrinking remainder; the square is kept by a running
// add, so no multiplier is needed. Each trial goes through a restoring divider
// that yields one quotient bit per cycle, and a hit repeats the trial with the
// same divisor. A prime near 2^32 needs about 32768 trials. One number is worked
// on at a time. The result sits in an output register, so the next number is
// taken while the previous result still waits for m_ready.
module largest_prime_factor (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lpf_pkg::FIELD_W-1:0] s_number,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lpf_pkg::FIELD_W-1:0] m_largest_factor,
    output logic                        m_has_factor
);
    import lpf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencing
    lpf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic and result register
    lpf_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .number         (s_number),
        .largest_factor (m_largest_factor),
        .has_factor     (m_has_factor)
    );

`include "largest_prime_factor_assert.svh"

    // no factor means the factor field reads zero
    `LPF_ASSERT_IMPL(a_none_is_zero, m_valid && !m_has_factor, m_largest_factor == '0)
    // any reported factor is at least two
    `LPF_ASSERT_IMPL(a_factor_min, m_valid && m_has_factor, m_largest_factor >= FIELD_W'(2))
    // the divider never reports done right after a start
    `LPF_ASSERT_NEXT(a_div_latency, cmd.div_start, !stat.div_done)
    // at most one datapath command per cycle
    `LPF_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0(cmd))

endmodule
